// ----- rtl/core/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned CAP_W      = 5;
  localparam int unsigned DATA_W     = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index as decoded from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // request opcodes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // summary flags of one sweep over the entries
  typedef struct packed {
    logic match;
    logic victim;
    logic free;
  } scan_flags_t;

endpackage

// ----- rtl/core/lkvc_ram.sv -----
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lkvc_scan.sv -----
// ----------------------------------------------------------------------------
// lkvc_scan
// Compare unit for the entry sweep: one entry per cycle, tracks key match,
// least recent entry and first free slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_scan #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic                                en_i,
  input  logic [$clog2(ENTRIES)-1:0]          idx_i,
  input  logic                                valid_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  value_i,
  input  logic [$clog2(ENTRIES)-1:0]          rank_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  lookup_key_i,
  output lkvc_pkg::scan_flags_t               flags_o,
  output logic [$clog2(ENTRIES)-1:0]          match_idx_o,
  output logic [$clog2(ENTRIES)-1:0]          match_rank_o,
  output logic signed [lkvc_pkg::DATA_W-1:0]  match_value_o,
  output logic [$clog2(ENTRIES)-1:0]          victim_idx_o,
  output logic signed [lkvc_pkg::DATA_W-1:0]  victim_key_o,
  output logic [$clog2(ENTRIES)-1:0]          free_idx_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  lkvc_pkg::scan_flags_t flags_q, flags_d;
  logic [IW-1:0]                      match_idx_q, match_rank_q;
  logic signed [lkvc_pkg::DATA_W-1:0] match_value_q;
  logic [IW-1:0]                      victim_idx_q, victim_rank_q;
  logic signed [lkvc_pkg::DATA_W-1:0] victim_key_q;
  logic [IW-1:0]                      free_idx_q;
  logic take_match, take_victim, take_free;

  always_comb begin
    take_match  = en_i && valid_i && (key_i == lookup_key_i) && !flags_q.match;
    take_victim = en_i && valid_i && (!flags_q.victim || (rank_i > victim_rank_q));
    take_free   = en_i && !valid_i && !flags_q.free;
    flags_d        = flags_q;
    flags_d.match  = flags_q.match  || take_match;
    flags_d.victim = flags_q.victim || take_victim;
    flags_d.free   = flags_q.free   || take_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (clear_i) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_match) begin
      match_idx_q   <= idx_i;
      match_rank_q  <= rank_i;
      match_value_q <= value_i;
    end
    if (take_victim) begin
      victim_idx_q  <= idx_i;
      victim_rank_q <= rank_i;
      victim_key_q  <= key_i;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
  end

  assign flags_o       = flags_q;
  assign match_idx_o   = match_idx_q;
  assign match_rank_o  = match_rank_q;
  assign match_value_o = match_value_q;
  assign victim_idx_o  = victim_idx_q;
  assign victim_key_o  = victim_key_q;
  assign free_idx_o    = free_idx_q;

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// One request at a time: input stalls from accept until the result is loaded into
// the output register, which waits while the output stalls. Each request makes
// two sweeps over the memories, one entry per cycle: compare, then rank rewrite
// (no get miss). Reset clears valid bits, occupancy and capacity (to 16); memories
// keep data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] write_value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic signed [lkvc_pkg::DATA_W-1:0] read_value_o,
  output logic                               evicted_o,
  output logic signed [lkvc_pkg::DATA_W-1:0] evicted_key_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned CNTW = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CNTW > lkvc_pkg::CAP_W) ? CNTW : lkvc_pkg::CAP_W;
  localparam int unsigned DW   = lkvc_pkg::DATA_W;

  // configuration
  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic                       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == lkvc_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == lkvc_pkg::REG_CAPACITY) ?
                  {{(32-lkvc_pkg::CAP_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_q <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  // sequencer state
  lkvc_pkg::state_e state_q, state_d;
  logic [CNTW-1:0]  cnt_q;
  logic             rd_vld_q;
  logic [IW-1:0]    rd_idx_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNTW-1:0]  occ_q;
  logic             out_valid_q;

  // latched request
  logic                 func_q;
  logic signed [DW-1:0] key_q, wval_q;

  // plan for the rank sweep
  logic          mode_insert_q;
  logic [IW-1:0] upd_slot_q, upd_rank_q;

  // pending result and output register
  logic                 res_hit_q, res_ev_q;
  logic signed [DW-1:0] res_rv_q, res_evk_q;
  logic                 hit_q, ev_q;
  logic signed [DW-1:0] rv_q, evk_q;

  // control decode
  logic accept, issue_rd, scan_en, decide, upd_we, cnt_last, out_free, load_out;

  // memory ports
  logic signed [DW-1:0] key_rdata, val_rdata;
  logic [IW-1:0]        rank_rdata, rank_eff, rank_wdata;
  logic                 key_we, val_we;
  logic [IW-1:0]        val_waddr;
  logic [IW-1:0]        rd_addr;
  logic                 rd_valid_bit;

  // scan results
  lkvc_pkg::scan_flags_t flags;
  logic [IW-1:0]         match_idx, match_rank, victim_idx, free_idx;
  logic signed [DW-1:0]  match_value, victim_key;

  // decision
  logic [CMPW-1:0] cap_ext, eff_cap, occ_ext;
  logic            is_put, put_miss, evict, fill_found;
  logic [IW-1:0]   fill_idx;

  assign cnt_last = (cnt_q == CNTW'(ENTRIES));
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_addr  = cnt_q[IW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lkvc_pkg::ST_SCAN;
      end
      lkvc_pkg::ST_SCAN: begin
        if (cnt_last) state_d = lkvc_pkg::ST_DECIDE;
      end
      lkvc_pkg::ST_DECIDE: begin
        if (flags.match || (put_miss && fill_found)) state_d = lkvc_pkg::ST_UPDATE;
        else state_d = lkvc_pkg::ST_DONE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (cnt_last) state_d = lkvc_pkg::ST_DONE;
      end
      lkvc_pkg::ST_DONE: begin
        if (out_free) state_d = lkvc_pkg::ST_IDLE;
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    issue_rd   = 1'b0;
    scan_en    = 1'b0;
    decide     = 1'b0;
    upd_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      lkvc_pkg::ST_SCAN: begin
        issue_rd = !cnt_last;
        scan_en  = rd_vld_q;
      end
      lkvc_pkg::ST_DECIDE: begin
        decide = 1'b1;
      end
      lkvc_pkg::ST_UPDATE: begin
        issue_rd = !cnt_last;
        upd_we   = rd_vld_q;
      end
      lkvc_pkg::ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lkvc_pkg::ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue_rd;
      if (accept || decide) begin
        cnt_q <= '0;
      end else if (issue_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr;
    if (accept) begin
      func_q <= func_i;
      key_q  <= lookup_key_i;
      wval_q <= write_value_i;
    end
  end

  // memories
  lkvc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (fill_idx),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  lkvc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (wval_q),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  lkvc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (upd_we),
    .waddr_i (rd_idx_q),
    .wdata_i (rank_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rank_rdata)
  );

  // an entry that is not valid reads rank zero
  assign rd_valid_bit = valid_q[rd_idx_q];
  assign rank_eff     = rd_valid_bit ? rank_rdata : '0;

  lkvc_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (accept),
    .en_i          (scan_en),
    .idx_i         (rd_idx_q),
    .valid_i       (rd_valid_bit),
    .key_i         (key_rdata),
    .value_i       (val_rdata),
    .rank_i        (rank_eff),
    .lookup_key_i  (key_q),
    .flags_o       (flags),
    .match_idx_o   (match_idx),
    .match_rank_o  (match_rank),
    .match_value_o (match_value),
    .victim_idx_o  (victim_idx),
    .victim_key_o  (victim_key),
    .free_idx_o    (free_idx)
  );

  // decision after the compare sweep
  always_comb begin
    cap_ext = CMPW'(cap_q);
    occ_ext = CMPW'(occ_q);
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    is_put     = (func_q == lkvc_pkg::FUNC_PUT);
    put_miss   = is_put && !flags.match;
    evict      = put_miss && flags.victim && (occ_ext >= eff_cap);
    fill_found = flags.free || evict;
    // after eviction the first free slot is the lower of the two
    if (flags.free && (!evict || (free_idx < victim_idx))) begin
      fill_idx = free_idx;
    end else begin
      fill_idx = victim_idx;
    end
    key_we    = decide && put_miss && fill_found;
    val_we    = decide && is_put && (flags.match || fill_found);
    val_waddr = flags.match ? match_idx : fill_idx;
  end

  // drop the victim, then claim the fill slot (which may be the same entry)
  always_comb begin
    valid_d = valid_q;
    if (evict) valid_d[victim_idx] = 1'b0;
    if (fill_found) valid_d[fill_idx] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (decide && put_miss) begin
      valid_q <= valid_d;
      occ_q   <= occ_q + CNTW'(fill_found) - CNTW'(evict);
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide) begin
      mode_insert_q <= !flags.match;
      upd_slot_q    <= flags.match ? match_idx : fill_idx;
      upd_rank_q    <= match_rank;
      res_hit_q     <= flags.match;
      res_ev_q      <= evict;
      res_evk_q     <= evict ? victim_key : '0;
      if (is_put) begin
        res_rv_q <= '0;
      end else begin
        res_rv_q <= flags.match ? match_value : '1;
      end
    end
  end

  // rank rewrite: promoted or inserted slot goes to zero; other valid entries age, on a hit only those below its rank
  always_comb begin
    if (rd_idx_q == upd_slot_q) begin
      rank_wdata = '0;
    end else if (mode_insert_q) begin
      rank_wdata = rd_valid_bit ? IW'(rank_eff + 1'b1) : rank_eff;
    end else if (rd_valid_bit && (rank_eff < upd_rank_q)) begin
      rank_wdata = IW'(rank_eff + 1'b1);
    end else begin
      rank_wdata = rank_eff;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      hit_q <= res_hit_q;
      rv_q  <= res_rv_q;
      ev_q  <= res_ev_q;
      evk_q <= res_evk_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rv_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while a request is in flight");

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q)
    else $error("occupancy disagrees with valid bits");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNTW'(ENTRIES))
    else $error("occupancy above entry count");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("result reports both hit and eviction");
`endif

endmodule
